/* hdl/rtt_pkg.sv */
// Shared types, codes and constants for the retransmission timer table.
package rtt_pkg;

   localparam int DEFAULT_TABLE_DEPTH = 16;

   localparam int ID_W       = 16;
   localparam int COUNT_W    = 9;
   localparam int TIME_W     = 32;
   localparam int MAX_W      = 8;
   localparam int TIMEOUT_W  = 16;
   localparam int CSR_IDX_W  = 8;
   localparam int CSR_DATA_W = 16;

   localparam logic [COUNT_W-1:0] COUNT_MAX   = '1;
   localparam logic [MAX_W-1:0]   MAX_RESET   = 8'd3;
   localparam logic [TIMEOUT_W-1:0] TMO_RESET = 16'd5;

   typedef enum logic [1:0] {
      REQ_NEW      = 2'd0,
      REQ_RESPONSE = 2'd1,
      REQ_TICK     = 2'd2,
      REQ_REMOVE   = 2'd3
   } req_kind_type;

   typedef enum logic [2:0] {
      EV_SEND       = 3'd0,
      EV_GAVE_UP    = 3'd1,
      EV_ACKED      = 3'd2,
      EV_NOT_FOUND  = 3'd3,
      EV_REMOVED    = 3'd4,
      EV_TABLE_FULL = 3'd5,
      EV_TICK_DONE  = 3'd6
   } event_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MAX_RESEND       = 8'd0,
      CSR_RESPONSE_TIMEOUT = 8'd1
   } csr_reg_type;

   // One stored table slot.
   typedef struct packed {
      logic [ID_W-1:0]    id;
      logic [COUNT_W-1:0] count;
      logic [TIME_W-1:0]  deadline;
   } slot_type;

   // Verdict of the slot evaluator for the slot under the scan pointer.
   typedef struct packed {
      logic free;
      logic match;
      logic give_up;
      logic resend;
   } verdict_type;

endpackage

/* hdl/rtt_slot_mem.sv */
// Slot storage: id, resend count and deadline, one write and one registered read port.
module rtt_slot_mem
   import rtt_pkg::*;
#(
   parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH,
   parameter int IDX_W       = 4
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [IDX_W-1:0] wr_addr,
   input  slot_type         wr_data,
   input  logic [IDX_W-1:0] rd_addr,
   output slot_type         rd_data
);

   slot_type mem_ff [TABLE_DEPTH];
   slot_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* hdl/rtt_eval.sv */
// Slot evaluator: id match, free check, give-up and deadline compares, count increment.
module rtt_eval
   import rtt_pkg::*;
(
   input  logic               slot_valid,
   input  logic               slot_done,
   input  slot_type           slot,
   input  logic [ID_W-1:0]    req_id,
   input  logic [TIME_W-1:0]  now,
   input  logic [MAX_W-1:0]   max_resend,
   output verdict_type        verdict,
   output logic [COUNT_W-1:0] count_next
);

   logic live;

   always_comb begin
      live            = slot_valid && !slot_done;
      verdict.free    = !slot_valid;
      verdict.match   = slot_valid && (slot.id == req_id);
      verdict.give_up = live && (slot.count > {1'b0, max_resend});
      verdict.resend  = live && !verdict.give_up && (slot.deadline < now);
      // saturate the resend count
      if (slot.count == COUNT_MAX) begin
         count_next = slot.count;
      end else begin
         count_next = slot.count + COUNT_W'(1);
      end
   end

endmodule

/* hdl/retransmit_timeout_table_core.sv */
// Top level of the retransmission timer table: sequencer, status bits and registers.
//
//  channel   ports                                         handshake
//  request   start, busy, req_type, req_message_id, req_now  start && !busy
//  response  rsp_valid, rsp_event_res, rsp_event_id, rsp_last one-cycle strobe
//  csr       csr_valid, csr_ready, csr_index, csr_wdata     csr_valid && csr_ready
//
// Every request walks the slots one per cycle through the shared slot evaluator,
// fed by the slot memory read port one slot ahead. A tick walks every slot and
// then a finish state; new, response and remove stop at the first hit or the last slot.
// Results leave from registers in the cycle after the slot or finish state that causes them.
// Reset clears all valid and done bits at once; no clearing pass is needed.
// The response side cannot stall; csr_ready is always high.
module retransmit_timeout_table_core
   import rtt_pkg::*;
#(
   parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [1:0]            req_type,
   input  logic [ID_W-1:0]       req_message_id,
   input  logic [TIME_W-1:0]     req_now,
   output logic                  rsp_valid,
   output logic [2:0]            rsp_event_res,
   output logic [ID_W-1:0]       rsp_event_id,
   output logic                  rsp_last,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_FINISH
   } state_type;

   state_type              state_ff;
   req_kind_type           kind_ff;
   logic [ID_W-1:0]        id_ff;
   logic [TIME_W-1:0]      now_ff;
   logic [TIME_W-1:0]      deadline_ff;
   logic [IDX_W-1:0]       idx_ff;
   logic [TABLE_DEPTH-1:0] valid_ff;
   logic [TABLE_DEPTH-1:0] done_ff;
   logic [MAX_W-1:0]       max_resend_ff;
   logic [TIMEOUT_W-1:0]   timeout_ff;
   logic                   rsp_valid_ff;
   event_type              rsp_event_ff;
   logic [ID_W-1:0]        rsp_id_ff;
   logic                   rsp_last_ff;

   logic                   accept;
   logic [TIME_W:0]        deadline_sum;
   logic [TIME_W-1:0]      deadline_in;
   logic                   wr_en;
   slot_type               wr_data;
   logic [IDX_W-1:0]       rd_addr;
   slot_type               rd_data;
   verdict_type            verdict;
   logic [COUNT_W-1:0]     count_next;
   logic                   last_slot;

   assign busy      = (state_ff != S_IDLE);
   assign accept    = start && !busy;
   assign csr_ready = 1'b1;
   assign last_slot = (idx_ff == LAST_IDX);

   // saturating deadline, computed once per request
   always_comb begin
      deadline_sum = {1'b0, req_now} + {{(TIME_W + 1 - TIMEOUT_W){1'b0}}, timeout_ff};
      deadline_in  = deadline_sum[TIME_W] ? '1 : deadline_sum[TIME_W-1:0];
   end

   // read one slot ahead of the evaluation pointer
   assign rd_addr = (state_ff == S_SCAN) ? idx_ff + IDX_W'(1) : '0;

   rtt_slot_mem #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .IDX_W       (IDX_W)
   ) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (idx_ff),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   rtt_eval u_eval (
      .slot_valid (valid_ff[idx_ff]),
      .slot_done  (done_ff[idx_ff]),
      .slot       (rd_data),
      .req_id     (id_ff),
      .now        (now_ff),
      .max_resend (max_resend_ff),
      .verdict    (verdict),
      .count_next (count_next)
   );

   always_comb begin
      wr_en   = 1'b0;
      wr_data = rd_data;
      if (state_ff == S_SCAN) begin
         if (kind_ff == REQ_NEW && verdict.free) begin
            wr_en            = 1'b1;
            wr_data.id       = id_ff;
            wr_data.count    = COUNT_W'(1);
            wr_data.deadline = deadline_ff;
         end else if (kind_ff == REQ_TICK && verdict.resend) begin
            wr_en            = 1'b1;
            wr_data.count    = count_next;
            wr_data.deadline = deadline_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         valid_ff      <= '0;
         done_ff       <= '0;
         max_resend_ff <= MAX_RESET;
         timeout_ff    <= TMO_RESET;
         rsp_valid_ff  <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;

         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               CSR_MAX_RESEND:       max_resend_ff <= csr_wdata[MAX_W-1:0];
               CSR_RESPONSE_TIMEOUT: timeout_ff    <= csr_wdata[TIMEOUT_W-1:0];
               default: ;
            endcase
         end

         unique case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  kind_ff     <= req_kind_type'(req_type);
                  id_ff       <= req_message_id;
                  now_ff      <= req_now;
                  deadline_ff <= deadline_in;
                  idx_ff      <= '0;
                  state_ff    <= S_SCAN;
               end
            end

            S_SCAN: begin
               idx_ff <= idx_ff + IDX_W'(1);
               unique case (kind_ff)
                  REQ_NEW: begin
                     if (verdict.free) begin
                        valid_ff[idx_ff] <= 1'b1;
                        done_ff[idx_ff]  <= 1'b0;
                        rsp_valid_ff     <= 1'b1;
                        rsp_event_ff     <= EV_SEND;
                        rsp_id_ff        <= id_ff;
                        rsp_last_ff      <= 1'b1;
                        state_ff         <= S_IDLE;
                     end else if (last_slot) begin
                        rsp_valid_ff <= 1'b1;
                        rsp_event_ff <= EV_TABLE_FULL;
                        rsp_id_ff    <= id_ff;
                        rsp_last_ff  <= 1'b1;
                        state_ff     <= S_IDLE;
                     end
                  end

                  REQ_RESPONSE, REQ_REMOVE: begin
                     if (verdict.match) begin
                        if (kind_ff == REQ_RESPONSE) begin
                           done_ff[idx_ff] <= 1'b1;
                           rsp_event_ff    <= EV_ACKED;
                        end else begin
                           valid_ff[idx_ff] <= 1'b0;
                           done_ff[idx_ff]  <= 1'b0;
                           rsp_event_ff     <= EV_REMOVED;
                        end
                        rsp_valid_ff <= 1'b1;
                        rsp_id_ff    <= id_ff;
                        rsp_last_ff  <= 1'b1;
                        state_ff     <= S_IDLE;
                     end else if (last_slot) begin
                        rsp_valid_ff <= 1'b1;
                        rsp_event_ff <= EV_NOT_FOUND;
                        rsp_id_ff    <= id_ff;
                        rsp_last_ff  <= 1'b1;
                        state_ff     <= S_IDLE;
                     end
                  end

                  REQ_TICK: begin
                     if (verdict.give_up) begin
                        done_ff[idx_ff] <= 1'b1;
                        rsp_valid_ff    <= 1'b1;
                        rsp_event_ff    <= EV_GAVE_UP;
                        rsp_id_ff       <= rd_data.id;
                        rsp_last_ff     <= 1'b0;
                     end else if (verdict.resend) begin
                        rsp_valid_ff <= 1'b1;
                        rsp_event_ff <= EV_SEND;
                        rsp_id_ff    <= rd_data.id;
                        rsp_last_ff  <= 1'b0;
                     end
                     if (last_slot) begin
                        state_ff <= S_FINISH;
                     end
                  end

                  default: ;
               endcase
            end

            S_FINISH: begin
               rsp_valid_ff <= 1'b1;
               rsp_event_ff <= EV_TICK_DONE;
               rsp_id_ff    <= '0;
               rsp_last_ff  <= 1'b1;
               state_ff     <= S_IDLE;
            end

            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_event_res = rsp_event_ff;
   assign rsp_event_id  = rsp_id_ff;
   assign rsp_last      = rsp_last_ff;

endmodule

/* bench/testbench.sv */
// Self-checking bench for the retransmission timer table core.
module testbench
   import rtt_pkg::*;
();

   localparam int TABLE_DEPTH = DEFAULT_TABLE_DEPTH;
   localparam int CYCLE_LIMIT = 250000;
   localparam int SETTLE_CYCLES = TABLE_DEPTH + 6;

   typedef struct packed {
      event_type       res;
      logic [ID_W-1:0] id;
      logic            last;
   } table_event_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  start = 1'b0;
   logic                  busy;
   logic [1:0]            req_type = REQ_NEW;
   logic [ID_W-1:0]       req_message_id = '0;
   logic [TIME_W-1:0]     req_now = '0;
   logic                  rsp_valid;
   logic [2:0]            rsp_event_res;
   logic [ID_W-1:0]       rsp_event_id;
   logic                  rsp_last;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // shadow copy of the table and its registers
   logic                 tbl_valid    [TABLE_DEPTH];
   logic                 tbl_done     [TABLE_DEPTH];
   logic [ID_W-1:0]      tbl_id       [TABLE_DEPTH];
   logic [COUNT_W-1:0]   tbl_count    [TABLE_DEPTH];
   logic [TIME_W-1:0]    tbl_deadline [TABLE_DEPTH];
   logic [MAX_W-1:0]     cfg_max_resend;
   logic [TIMEOUT_W-1:0] cfg_timeout;

   table_event_type pending_events[$];
   int              mismatches = 0;
   int              cycle_count = 0;
   bit              no_gaps = 1'b0;
   logic [TIME_W-1:0] wall_time;
   logic [ID_W-1:0] id_pool [8];

   retransmit_timeout_table_core #(.TABLE_DEPTH(TABLE_DEPTH)) u_dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_type       (req_type),
      .req_message_id (req_message_id),
      .req_now        (req_now),
      .rsp_valid      (rsp_valid),
      .rsp_event_res  (rsp_event_res),
      .rsp_event_id   (rsp_event_id),
      .rsp_last       (rsp_last),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAILED: results differ");
         $finish;
      end
   end

   always @(posedge clock) begin
      table_event_type want;
      if (!reset && rsp_valid) begin
         if (pending_events.size() == 0) begin
            $error("unexpected event: event_res %0d event_id %0h", rsp_event_res, rsp_event_id);
            mismatches++;
         end else begin
            want = pending_events.pop_front();
            if (rsp_event_res !== want.res) begin
               $error("event_res expected %0d actual %0d", want.res, rsp_event_res);
               mismatches++;
            end
            if (rsp_event_id !== want.id) begin
               $error("event_id expected %0h actual %0h", want.id, rsp_event_id);
               mismatches++;
            end
            if (rsp_last !== want.last) begin
               $error("last expected %0d actual %0d", want.last, rsp_last);
               mismatches++;
            end
         end
      end
   end

   function automatic void note_event(event_type res, logic [ID_W-1:0] id, logic last);
      table_event_type ev;
      ev.res  = res;
      ev.id   = id;
      ev.last = last;
      pending_events.push_back(ev);
   endfunction

   function automatic logic [TIME_W-1:0] reload_deadline(logic [TIME_W-1:0] now_val);
      logic [TIME_W:0] sum;
      sum = {1'b0, now_val} + {{(TIME_W + 1 - TIMEOUT_W){1'b0}}, cfg_timeout};
      return sum[TIME_W] ? {TIME_W{1'b1}} : sum[TIME_W-1:0];
   endfunction

   // Update the shadow table for one accepted request and queue its events.
   function automatic void advance_timer_table(req_kind_type kind, logic [ID_W-1:0] id,
                                               logic [TIME_W-1:0] now_val);
      int slot;
      slot = -1;
      case (kind)
         REQ_NEW: begin
            for (int i = 0; i < TABLE_DEPTH; i++)
               if (!tbl_valid[i] && slot < 0)
                  slot = i;
            if (slot < 0) begin
               note_event(EV_TABLE_FULL, id, 1'b1);
            end else begin
               tbl_valid[slot]    = 1'b1;
               tbl_done[slot]     = 1'b0;
               tbl_id[slot]       = id;
               tbl_count[slot]    = COUNT_W'(1);
               tbl_deadline[slot] = reload_deadline(now_val);
               note_event(EV_SEND, id, 1'b1);
            end
         end
         REQ_RESPONSE, REQ_REMOVE: begin
            for (int i = 0; i < TABLE_DEPTH; i++)
               if (tbl_valid[i] && tbl_id[i] == id && slot < 0)
                  slot = i;
            if (slot < 0) begin
               note_event(EV_NOT_FOUND, id, 1'b1);
            end else if (kind == REQ_RESPONSE) begin
               tbl_done[slot] = 1'b1;
               note_event(EV_ACKED, id, 1'b1);
            end else begin
               tbl_valid[slot] = 1'b0;
               tbl_done[slot]  = 1'b0;
               note_event(EV_REMOVED, id, 1'b1);
            end
         end
         default: begin
            for (int i = 0; i < TABLE_DEPTH; i++) begin
               if (tbl_valid[i] && !tbl_done[i]) begin
                  if (tbl_count[i] > {1'b0, cfg_max_resend}) begin
                     tbl_done[i] = 1'b1;
                     note_event(EV_GAVE_UP, tbl_id[i], 1'b0);
                  end else if (tbl_deadline[i] < now_val) begin
                     note_event(EV_SEND, tbl_id[i], 1'b0);
                     if (tbl_count[i] != COUNT_MAX)
                        tbl_count[i] = tbl_count[i] + COUNT_W'(1);
                     tbl_deadline[i] = reload_deadline(now_val);
                  end
               end
            end
            note_event(EV_TICK_DONE, '0, 1'b1);
         end
      endcase
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (no_gaps || r < 60)
         return 0;
      if (r < 93)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Entered right after an accept edge or while start is low; start stays high
   // across back-to-back requests.
   task automatic issue_request(req_kind_type kind, logic [ID_W-1:0] id,
                                logic [TIME_W-1:0] now_val);
      int gap;
      gap = pick_gap();
      @(negedge clock);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      start          <= 1'b1;
      req_type       <= kind;
      req_message_id <= id;
      req_now        <= now_val;
      do @(posedge clock); while (busy);
      advance_timer_table(kind, id, now_val);
   endtask

   // Drop start and drain every outstanding event.
   task automatic settle_table();
      @(negedge clock);
      start <= 1'b0;
      while (pending_events.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      while (busy)
         @(posedge clock);
   endtask

   task automatic write_register(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      if (idx == CSR_MAX_RESEND)
         cfg_max_resend = data[MAX_W-1:0];
      else if (idx == CSR_RESPONSE_TIMEOUT)
         cfg_timeout = data[TIMEOUT_W-1:0];
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic test_basic_ops();
      // out-of-range indexes must leave both registers alone
      write_register(8'd2, 16'hA5A5);
      write_register(8'hFF, 16'h5A5A);
      issue_request(REQ_TICK, '0, 32'd0);
      issue_request(REQ_RESPONSE, 16'h1234, 32'd0);
      issue_request(REQ_REMOVE, 16'hFFFF, 32'hFFFF_FFFF);
      issue_request(REQ_NEW, 16'h0000, 32'd0);
      issue_request(REQ_NEW, 16'hFFFF, 32'hFFFF_FFFE);
      issue_request(REQ_NEW, 16'h0000, 32'd100);
      issue_request(REQ_RESPONSE, 16'h0000, 32'd0);
      issue_request(REQ_RESPONSE, 16'h0000, 32'd0);
      issue_request(REQ_TICK, '0, 32'd106);
      issue_request(REQ_TICK, '0, 32'd200);
      issue_request(REQ_TICK, '0, 32'd300);
      issue_request(REQ_TICK, '0, 32'd400);
      issue_request(REQ_TICK, '0, 32'hFFFF_FFFF);
      issue_request(REQ_REMOVE, 16'h0000, 32'd0);
      issue_request(REQ_REMOVE, 16'h0000, 32'd0);
      issue_request(REQ_RESPONSE, 16'h0000, 32'd0);
      issue_request(REQ_REMOVE, 16'hFFFF, 32'd0);
      issue_request(REQ_TICK, '0, 32'hFFFF_FFFF);
      settle_table();
   endtask

   task automatic test_table_full();
      for (int i = 0; i < TABLE_DEPTH; i++)
         issue_request(REQ_NEW, 16'h0100 + ID_W'(i), TIME_W'(i));
      issue_request(REQ_NEW, 16'hDEAD, 32'd50);
      issue_request(REQ_REMOVE, 16'h0105, 32'd0);
      issue_request(REQ_NEW, 16'hBEEF, 32'd60);
      // every slot resends in one tick
      issue_request(REQ_TICK, '0, 32'd1000);
      for (int i = 0; i < TABLE_DEPTH; i++)
         issue_request(REQ_REMOVE, (i == 5) ? 16'hBEEF : 16'h0100 + ID_W'(i), 32'd0);
      settle_table();
   endtask

   task automatic test_register_extremes();
      write_register(CSR_MAX_RESEND, 16'h0000);
      write_register(CSR_RESPONSE_TIMEOUT, 16'h0000);
      issue_request(REQ_NEW, 16'h00AA, 32'd10);
      issue_request(REQ_TICK, '0, 32'd10);
      issue_request(REQ_RESPONSE, 16'h00AA, 32'd0);
      issue_request(REQ_REMOVE, 16'h00AA, 32'd0);
      settle_table();
      write_register(CSR_MAX_RESEND, 16'hFFFF);
      write_register(CSR_RESPONSE_TIMEOUT, 16'hFFFF);
      issue_request(REQ_NEW, 16'h5555, 32'hFFFF_0001);
      issue_request(REQ_NEW, 16'hAAAA, 32'd0);
      issue_request(REQ_TICK, '0, 32'd65535);
      issue_request(REQ_TICK, '0, 32'd65536);
      issue_request(REQ_TICK, '0, 32'hFFFF_FFFF);
      issue_request(REQ_REMOVE, 16'h5555, 32'd0);
      issue_request(REQ_REMOVE, 16'hAAAA, 32'd0);
      settle_table();
      // upper bits of the max_resend write are dropped
      write_register(CSR_MAX_RESEND, 16'hAA03);
      write_register(CSR_RESPONSE_TIMEOUT, 16'h0005);
   endtask

   task automatic test_random_traffic();
      req_kind_type    kind;
      logic [ID_W-1:0] id;
      logic [TIME_W-1:0] now_val;
      int r;
      for (int phase = 0; phase < 8; phase++) begin
         settle_table();
         for (int k = 0; k < 8; k++)
            id_pool[k] = ID_W'($urandom);
         r = $urandom_range(0, 99);
         write_register(CSR_MAX_RESEND, CSR_DATA_W'((r < 50) ? $urandom_range(0, 4) :
                        (r < 65) ? 32'h0000 : (r < 80) ? 32'h00FF : $urandom));
         r = $urandom_range(0, 99);
         write_register(CSR_RESPONSE_TIMEOUT, CSR_DATA_W'((r < 55) ? $urandom_range(0, 10) :
                        (r < 70) ? 32'h0000 : (r < 80) ? 32'hFFFF : $urandom));
         if ($urandom_range(0, 3) == 0)
            write_register(CSR_IDX_W'($urandom_range(2, 255)), CSR_DATA_W'($urandom));
         no_gaps   = (phase % 3 == 1);
         wall_time = $urandom_range(0, 1000);
         for (int n = 0; n < 40; n++) begin
            r = $urandom_range(0, 99);
            if (r < 35)
               kind = REQ_NEW;
            else if (r < 50)
               kind = REQ_RESPONSE;
            else if (r < 70)
               kind = REQ_REMOVE;
            else
               kind = REQ_TICK;
            id = ($urandom_range(0, 99) < 85) ? id_pool[$urandom_range(0, 7)] :
                 ID_W'($urandom);
            r = $urandom_range(0, 99);
            wall_time = wall_time + $urandom_range(0, 6);
            if (r < 82)
               now_val = wall_time;
            else if (r < 92)
               now_val = $urandom;
            else
               now_val = 32'hFFFF_FFF0 + $urandom_range(0, 15);
            issue_request(kind, (kind == REQ_TICK) ? ID_W'($urandom) : id, now_val);
         end
      end
      no_gaps = 1'b0;
      settle_table();
   endtask

   initial begin
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         tbl_valid[i]    = 1'b0;
         tbl_done[i]     = 1'b0;
         tbl_id[i]       = '0;
         tbl_count[i]    = '0;
         tbl_deadline[i] = '0;
      end
      cfg_max_resend = MAX_RESET;
      cfg_timeout    = TMO_RESET;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_basic_ops();
      test_table_full();
      test_register_extremes();
      test_random_traffic();

      settle_table();
      if (mismatches == 0 && pending_events.size() == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule

/* retransmit_timeout_table_core.f */
hdl/rtt_pkg.sv
hdl/rtt_slot_mem.sv
hdl/rtt_eval.sv
hdl/retransmit_timeout_table_core.sv
bench/testbench.sv
